/* hdl/relation_property_checker_defines.svh */
// ----------------------------------------------------------------------------
// Assertion helpers for the relation property checker.
// Both check on the rising edge of clk and are disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef RELATION_PROPERTY_CHECKER_DEFINES_SVH
`define RELATION_PROPERTY_CHECKER_DEFINES_SVH

// Same-cycle implication.
`define RPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/rpc_pkg.sv */
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared widths and the table entry type of the relation property checker.
// ----------------------------------------------------------------------------
`default_nettype none

package rpc_pkg;

  localparam int ELEM_W  = 9;   // element and domain size width
  localparam int EPOCH_W = 8;   // relation tag kept with every table entry

  localparam logic [ELEM_W-1:0]  DOMAIN_RESET = 9'd256;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST  = 8'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST   = 8'hFF;
  localparam logic [EPOCH_W-1:0] EPOCH_STALE  = 8'd0;  // never a live tag

  // One table entry: valid only when tag matches the current relation.
  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [ELEM_W-1:0]  val;
  } rpc_entry_t;

endpackage

`default_nettype wire

/* hdl/relation_property_checker.sv */
// ----------------------------------------------------------------------------
// relation_property_checker
// Checks a streamed binary relation on 1..domain_size for the function,
// total, injective, surjective and bijective properties.
// ----------------------------------------------------------------------------
// Usage: present a pair on from_elem/to_elem/last_pair with start high; it is
// taken at any edge where busy is low, so one pair per cycle is sustained
// while busy stays low. The pair marked last_pair produces one result,
// registered through the input stage and the result register: done is high
// for exactly one cycle with the six flags beside it. The receiver cannot
// stall, so sample the flags whenever done is high. Unmarked pairs produce
// no result. Throughput is set by one read-modify-write per table (image and
// preimage), each a single-port-read memory with the previous write
// forwarded. busy is high after reset, and again after every 255th result,
// while a clearing pass resets the relation tags held in the tables. Write
// domain_size (cfg_data, cfg_valid; cfg_ready is always high) only between
// relations; a value above MAX_ELEMS acts as MAX_ELEMS.
// ----------------------------------------------------------------------------
`default_nettype none

`include "relation_property_checker_defines.svh"

module relation_property_checker import rpc_pkg::*; #(
  parameter int MAX_ELEMS = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // request channel
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [ELEM_W-1:0] from_elem,
  input  wire logic [ELEM_W-1:0] to_elem,
  input  wire logic              last_pair,
  // result
  output logic                   done,
  output logic                   is_function,
  output logic                   is_total,
  output logic                   is_injective,
  output logic                   is_surjective,
  output logic                   is_bijective,
  output logic                   range_error,
  // configuration
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [ELEM_W-1:0] cfg_data
);

  localparam int IDX_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ELEMS + 1);
  localparam int XW    = (IDX_W > ELEM_W) ? IDX_W : ELEM_W;   // address arithmetic
  localparam int NW    = (CNT_W > ELEM_W) ? CNT_W : ELEM_W;   // size compare

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [ELEM_W-1:0] domain_size;
  logic [NW-1:0]     n_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      domain_size <= DOMAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      domain_size <= cfg_data;
    end
  end

  assign n_eff = (NW'(domain_size) > NW'(MAX_ELEMS)) ? NW'(MAX_ELEMS) : NW'(domain_size);

  // --------------------------------------------------------------------------
  // Control: relation tag and clearing pass
  // --------------------------------------------------------------------------
  logic               accept;
  logic               wrap_pending;
  logic               clr_active;
  logic [IDX_W-1:0]   clr_addr;
  logic [EPOCH_W-1:0] epoch;

  // input stage
  logic               s1_valid;
  logic [ELEM_W-1:0]  s1_x;
  logic [ELEM_W-1:0]  s1_y;
  logic               s1_last;
  logic [IDX_W-1:0]   s1_xa;
  logic [IDX_W-1:0]   s1_ya;

  // the tag would roll over on this result: hold off the next request
  assign wrap_pending = s1_valid && s1_last && (epoch == EPOCH_LAST);
  assign busy         = clr_active || wrap_pending;
  assign accept       = start && !busy;

  // table addresses are element minus one
  logic [XW-1:0] x_ext;
  logic [XW-1:0] y_ext;

  assign x_ext = XW'(from_elem) - XW'(1);
  assign y_ext = XW'(to_elem) - XW'(1);

  always_ff @(posedge clk) begin
    s1_x  <= from_elem;
    s1_y  <= to_elem;
    s1_last <= last_pair;
    s1_xa <= x_ext[IDX_W-1:0];
    s1_ya <= y_ext[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      clr_active <= 1'b1;
      clr_addr   <= '0;
      epoch      <= EPOCH_FIRST;
    end else begin
      s1_valid <= accept;
      if (clr_active) begin
        clr_addr <= clr_addr + IDX_W'(1);
        if (clr_addr == IDX_W'(MAX_ELEMS - 1)) begin
          clr_active <= 1'b0;
        end
      end else if (s1_valid && s1_last) begin
        if (epoch == EPOCH_LAST) begin
          // every stale tag must go before a live one can alias it
          clr_active <= 1'b1;
          clr_addr   <= '0;
          epoch      <= EPOCH_FIRST;
        end else begin
          epoch <= epoch + EPOCH_W'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Image and preimage tables
  // --------------------------------------------------------------------------
  rpc_entry_t       img_rd;
  rpc_entry_t       pre_rd;
  rpc_entry_t       img_wr;
  rpc_entry_t       pre_wr;
  logic             img_we;
  logic             pre_we;
  logic [IDX_W-1:0] img_wa;
  logic [IDX_W-1:0] pre_wa;

  logic pair_bad;
  logic pair_ok;
  logic img_seen;
  logic pre_seen;
  logic img_conf;
  logic pre_conf;
  logic img_new;
  logic pre_new;

  assign pair_bad = (s1_x == '0) || (NW'(s1_x) > n_eff) ||
                    (s1_y == '0) || (NW'(s1_y) > n_eff);
  assign pair_ok  = s1_valid && !pair_bad;

  assign img_seen = (img_rd.tag == epoch);
  assign pre_seen = (pre_rd.tag == epoch);
  assign img_new  = pair_ok && !img_seen;
  assign pre_new  = pair_ok && !pre_seen;
  // repeated identical pair is no conflict
  assign img_conf = pair_ok && img_seen && (img_rd.val != s1_y);
  assign pre_conf = pair_ok && pre_seen && (pre_rd.val != s1_x);

  always_comb begin
    if (clr_active) begin
      img_we = 1'b1;
      pre_we = 1'b1;
      img_wa = clr_addr;
      pre_wa = clr_addr;
      img_wr = '{tag: EPOCH_STALE, val: '0};
      pre_wr = '{tag: EPOCH_STALE, val: '0};
    end else begin
      img_we = img_new;
      pre_we = pre_new;
      img_wa = s1_xa;
      pre_wa = s1_ya;
      img_wr = '{tag: epoch, val: s1_y};
      pre_wr = '{tag: epoch, val: s1_x};
    end
  end

  rpc_seen_table #(
    .DEPTH(MAX_ELEMS)
  ) u_image (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (x_ext[IDX_W-1:0]),
    .rd_entry(img_rd),
    .wr_en   (img_we),
    .wr_addr (img_wa),
    .wr_entry(img_wr)
  );

  rpc_seen_table #(
    .DEPTH(MAX_ELEMS)
  ) u_preimage (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (y_ext[IDX_W-1:0]),
    .rd_entry(pre_rd),
    .wr_en   (pre_we),
    .wr_addr (pre_wa),
    .wr_entry(pre_wr)
  );

  // --------------------------------------------------------------------------
  // Per-relation flags and coverage counts
  // --------------------------------------------------------------------------
  logic             not_function_flag;
  logic             not_injective_flag;
  logic             range_error_flag;
  logic [CNT_W-1:0] sources_covered;
  logic [CNT_W-1:0] targets_covered;

  logic             not_function_flag_next;
  logic             not_injective_flag_next;
  logic             range_error_flag_next;
  logic [CNT_W-1:0] sources_covered_next;
  logic [CNT_W-1:0] targets_covered_next;

  assign not_function_flag_next  = not_function_flag || img_conf;
  assign not_injective_flag_next = not_injective_flag || pre_conf;
  assign range_error_flag_next   = range_error_flag || (s1_valid && pair_bad);
  assign sources_covered_next    = sources_covered + CNT_W'(img_new);
  assign targets_covered_next    = targets_covered + CNT_W'(pre_new);

  always_ff @(posedge clk) begin
    if (rst) begin
      not_function_flag  <= 1'b0;
      not_injective_flag <= 1'b0;
      range_error_flag   <= 1'b0;
      sources_covered    <= '0;
      targets_covered    <= '0;
    end else if (s1_valid) begin
      if (s1_last) begin
        not_function_flag  <= 1'b0;
        not_injective_flag <= 1'b0;
        range_error_flag   <= 1'b0;
        sources_covered    <= '0;
        targets_covered    <= '0;
      end else begin
        not_function_flag  <= not_function_flag_next;
        not_injective_flag <= not_injective_flag_next;
        range_error_flag   <= range_error_flag_next;
        sources_covered    <= sources_covered_next;
        targets_covered    <= targets_covered_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic fn;
  logic tot;
  logic inj;
  logic sur;

  assign fn  = !not_function_flag_next && !range_error_flag_next;
  assign tot = fn && (NW'(sources_covered_next) == n_eff);
  assign inj = fn && !not_injective_flag_next;
  assign sur = fn && (NW'(targets_covered_next) == n_eff);

  always_ff @(posedge clk) begin
    is_function   <= fn;
    is_total      <= tot;
    is_injective  <= inj;
    is_surjective <= sur;
    is_bijective  <= inj && sur;
    range_error   <= range_error_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid && s1_last;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `RPC_ASSERT_NOW(a_epoch_live, 1'b1, epoch != EPOCH_STALE, "live tag equals stale tag")
  `RPC_ASSERT_NOW(a_no_pair_in_clear, clr_active, !s1_valid, "pair in flight during clear")
  `RPC_ASSERT_NEXT(a_done_after_last, s1_valid && s1_last, done, "marked pair gave no result")
  `RPC_ASSERT_NOW(a_range_gates, done && range_error, !is_function && !is_total && !is_injective && !is_surjective && !is_bijective, "flags set with range error")
  `RPC_ASSERT_NOW(a_bij_parts, done && is_bijective, is_function && is_injective && is_surjective, "bijective without its parts")

endmodule

`default_nettype wire

/* hdl/rpc_seen_table.sv */
// ----------------------------------------------------------------------------
// rpc_seen_table
// Tagged lookup table: one registered read and one write per cycle, with the
// write of the previous cycle forwarded onto the read that saw stale data.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_seen_table import rpc_pkg::*; #(
  parameter  int DEPTH = 256,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IDX_W-1:0] rd_addr,
  output rpc_entry_t            rd_entry,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire rpc_entry_t       wr_entry
);

  rpc_entry_t       mem [DEPTH];
  rpc_entry_t       mem_q;
  logic [IDX_W-1:0] rd_addr_q;
  logic             fwd_en;
  logic [IDX_W-1:0] fwd_addr;
  rpc_entry_t       fwd_entry;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    mem_q     <= mem[rd_addr];
    rd_addr_q <= rd_addr;
    fwd_addr  <= wr_addr;
    fwd_entry <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_en <= 1'b0;
    end else begin
      fwd_en <= wr_en;
    end
  end

  // read and write at the same edge: memory returned the old word
  assign rd_entry = (fwd_en && (fwd_addr == rd_addr_q)) ? fwd_entry : mem_q;

endmodule

`default_nettype wire

/* verif/rpc_flag_monitor.sv */
// ----------------------------------------------------------------------------
// rpc_flag_monitor
// Watches the pair, configuration and result ports of the relation property
// checker, predicts the six flags of each relation and compares them.
// ----------------------------------------------------------------------------
module rpc_flag_monitor import rpc_pkg::*; #(
  parameter int MAX_ELEMS = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [ELEM_W-1:0] from_elem,
  input  logic [ELEM_W-1:0] to_elem,
  input  logic              last_pair,
  input  logic              done,
  input  logic              is_function,
  input  logic              is_total,
  input  logic              is_injective,
  input  logic              is_surjective,
  input  logic              is_bijective,
  input  logic              range_error,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [ELEM_W-1:0] cfg_data,
  output int                mismatches,
  output int                flags_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic fn;
    logic tot;
    logic inj;
    logic sur;
    logic bij;
    logic rerr;
  } rel_flags_t;

  rel_flags_t        flags_due[$];
  logic [ELEM_W-1:0] dom_size;
  logic [ELEM_W-1:0] image_tbl   [MAX_ELEMS];
  logic [ELEM_W-1:0] preimage_tbl[MAX_ELEMS];
  bit                image_hit   [MAX_ELEMS];
  bit                preimage_hit[MAX_ELEMS];
  int                n_sources;
  int                n_targets;
  bit                multi_image;
  bit                multi_source;
  bit                bad_elem;
  int                errs = 0;

  function automatic void forget_relation();
    for (int i = 0; i < MAX_ELEMS; i++) begin
      image_hit[i]    = 1'b0;
      preimage_hit[i] = 1'b0;
    end
    n_sources    = 0;
    n_targets    = 0;
    multi_image  = 1'b0;
    multi_source = 1'b0;
    bad_elem     = 1'b0;
  endfunction

  // Fold one accepted request into the relation; a marked pair closes it.
  function automatic void absorb_pair(logic [ELEM_W-1:0] x, logic [ELEM_W-1:0] y,
                                      logic last);
    int         n;
    int         xi;
    int         yi;
    rel_flags_t f;
    n  = (int'(dom_size) > MAX_ELEMS) ? MAX_ELEMS : int'(dom_size);
    xi = int'(x) - 1;
    yi = int'(y) - 1;
    if (x == '0 || int'(x) > n || y == '0 || int'(y) > n) begin
      bad_elem = 1'b1;
    end else begin
      if (!image_hit[xi]) begin
        image_hit[xi] = 1'b1;
        image_tbl[xi] = y;
        n_sources++;
      end else if (image_tbl[xi] != y) begin
        multi_image = 1'b1;
      end
      if (!preimage_hit[yi]) begin
        preimage_hit[yi] = 1'b1;
        preimage_tbl[yi] = x;
        n_targets++;
      end else if (preimage_tbl[yi] != x) begin
        multi_source = 1'b1;
      end
    end
    if (last) begin
      f.fn   = !multi_image && !bad_elem;
      f.tot  = f.fn && (n_sources == n);
      f.inj  = f.fn && !multi_source;
      f.sur  = f.fn && (n_targets == n);
      f.bij  = f.inj && f.sur;
      f.rerr = bad_elem;
      flags_due.push_back(f);
      forget_relation();
    end
  endfunction

  always @(posedge clk) begin : watch
    rel_flags_t got;
    rel_flags_t want;
    if (rst) begin
      dom_size = DOMAIN_RESET;
      forget_relation();
      flags_due.delete();
    end else begin
      if (done) begin
        got = {is_function, is_total, is_injective, is_surjective, is_bijective,
               range_error};
        if (flags_due.size() == 0) begin
          if (errs < 10) begin
            $display("%0t: unexpected result fn=%b tot=%b inj=%b sur=%b bij=%b rerr=%b",
                     $time, got.fn, got.tot, got.inj, got.sur, got.bij, got.rerr);
          end
          errs++;
        end else begin
          want = flags_due.pop_front();
          if (got.fn !== want.fn || got.tot !== want.tot || got.inj !== want.inj ||
              got.sur !== want.sur || got.bij !== want.bij || got.rerr !== want.rerr) begin
            if (errs < 10) begin
              $display("%0t: flags mismatch, exp fn=%b tot=%b inj=%b sur=%b bij=%b rerr=%b",
                       $time, want.fn, want.tot, want.inj, want.sur, want.bij, want.rerr);
              $display("%0t:                 got fn=%b tot=%b inj=%b sur=%b bij=%b rerr=%b",
                       $time, got.fn, got.tot, got.inj, got.sur, got.bij, got.rerr);
            end
            errs++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        dom_size = cfg_data;
      end
      if (start && !busy) begin
        absorb_pair(from_elem, to_elem, last_pair);
      end
    end
    mismatches    <= errs;
    flags_pending <= flags_due.size();
  end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives relations of ordered pairs into the relation property checker under
// several domain sizes, with random gaps, and reports the monitor's verdict.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpc_pkg::*;

  localparam int MAX_ELEMS = 256;

  typedef struct packed {
    logic [ELEM_W-1:0] x;
    logic [ELEM_W-1:0] y;
  } pair_t;

  // Every input has a known value from time zero; reset is held from the start.
  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              start     = 1'b0;
  logic [ELEM_W-1:0] from_elem = '0;
  logic [ELEM_W-1:0] to_elem   = '0;
  logic              last_pair = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [ELEM_W-1:0] cfg_data  = '0;

  logic busy;
  logic cfg_ready;
  logic done;
  logic is_function;
  logic is_total;
  logic is_injective;
  logic is_surjective;
  logic is_bijective;
  logic range_error;

  int fails;
  int flags_pending;

  // Pairs of the relation currently being sent.
  pair_t rel_pairs[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  relation_property_checker #(
    .MAX_ELEMS (MAX_ELEMS)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .from_elem     (from_elem),
    .to_elem       (to_elem),
    .last_pair     (last_pair),
    .done          (done),
    .is_function   (is_function),
    .is_total      (is_total),
    .is_injective  (is_injective),
    .is_surjective (is_surjective),
    .is_bijective  (is_bijective),
    .range_error   (range_error),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  rpc_flag_monitor #(
    .MAX_ELEMS (MAX_ELEMS)
  ) u_mon (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .from_elem     (from_elem),
    .to_elem       (to_elem),
    .last_pair     (last_pair),
    .done          (done),
    .is_function   (is_function),
    .is_total      (is_total),
    .is_injective  (is_injective),
    .is_surjective (is_surjective),
    .is_bijective  (is_bijective),
    .range_error   (range_error),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mismatches    (fails),
    .flags_pending (flags_pending)
  );

  // Mostly back-to-back, sometimes a short gap, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Element outside 1..n but inside 0..MAX_ELEMS (0..256).
  function automatic logic [ELEM_W-1:0] stray_elem(int n);
    if (n >= MAX_ELEMS || $urandom_range(0, 1) == 0) return '0;
    return ELEM_W'($urandom_range(n + 1, MAX_ELEMS));
  endfunction

  // Present one request and hold it until it is taken. busy read just after
  // the edge is the value the block saw at that edge, so the loop exits on
  // the accepting edge. start stays high so that a following request can
  // go straight in on the next cycle.
  task automatic send_pair(input logic [ELEM_W-1:0] x, input logic [ELEM_W-1:0] y,
                           input logic last);
    start     <= 1'b1;
    from_elem <= x;
    to_elem   <= y;
    last_pair <= last;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for a while; with drain set, also sit until the monitor holds
  // no outstanding results. A drain never skips the wait for a clock edge, so the
  // pending count seen reflects the last accepted request, and start is never
  // lowered and raised within the same step.
  task automatic rest(input int cycles, input bit drain);
    int n;
    n = (drain && cycles == 0) ? 1 : cycles;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
      while (drain && flags_pending != 0) @(posedge clk);
    end
  endtask

  // domain_size only changes while the block is quiet: start is dropped and
  // the task waits until every result is in.
  task automatic write_domain(input logic [ELEM_W-1:0] value);
    rest(4, 1'b1);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Build one relation on 1..n into rel_pairs. Most are well-formed (partial
  // or total functions, often permutations) with random repeats, clashes and
  // stray elements mixed in; the rest is plain noise.
  task automatic build_relation(input int n, input bit full_perm);
    int    perm[MAX_ELEMS];
    int    kind;
    int    j;
    int    t;
    int    k;
    int    hi;
    bit    bij;
    pair_t p;
    rel_pairs.delete();
    for (int i = 0; i < n; i++) perm[i] = i + 1;
    for (int i = n - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      t       = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    hi   = (n < MAX_ELEMS) ? n + 1 : MAX_ELEMS;
    kind = full_perm ? 0 : $urandom_range(0, 9);
    if (kind < 8) begin
      bij = full_perm || ($urandom_range(0, 1) == 1);
      if (n <= 16 || full_perm) begin
        // small domain: walk every source, dropping a few unless total
        for (int x = 1; x <= n; x++) begin
          if (full_perm || kind < 3 || $urandom_range(0, 7) != 0) begin
            p.x = ELEM_W'(x);
            p.y = bij ? ELEM_W'(perm[x-1]) : ELEM_W'($urandom_range(1, n));
            rel_pairs.push_back(p);
          end
        end
      end else begin
        // wide domain: keep it short, a handful of sources
        k = $urandom_range(1, 12);
        repeat (k) begin
          t   = $urandom_range(1, n);
          p.x = ELEM_W'(t);
          p.y = bij ? ELEM_W'(perm[t-1]) : ELEM_W'($urandom_range(1, n));
          rel_pairs.push_back(p);
        end
      end
      if (!full_perm && rel_pairs.size() > 0) begin
        if ($urandom_range(0, 2) == 0) begin
          // repeated identical pair
          rel_pairs.push_back(rel_pairs[$urandom_range(0, rel_pairs.size() - 1)]);
        end
        if ($urandom_range(0, 3) == 0) begin
          // same source, likely a second image
          p   = rel_pairs[$urandom_range(0, rel_pairs.size() - 1)];
          p.y = ELEM_W'($urandom_range(1, n));
          rel_pairs.push_back(p);
        end
        if ($urandom_range(0, 3) == 0) begin
          // second source onto an existing target
          p   = rel_pairs[$urandom_range(0, rel_pairs.size() - 1)];
          p.x = ELEM_W'($urandom_range(1, n));
          rel_pairs.push_back(p);
        end
        if ($urandom_range(0, 5) == 0) begin
          if ($urandom_range(0, 1) == 1) begin
            p.x = stray_elem(n);
            p.y = ELEM_W'($urandom_range(0, MAX_ELEMS));
          end else begin
            p.x = ELEM_W'($urandom_range(1, n));
            p.y = stray_elem(n);
          end
          rel_pairs.push_back(p);
        end
      end
    end else begin
      k = $urandom_range(1, 8);
      repeat (k) begin
        p.x = ELEM_W'($urandom_range(0, hi));
        p.y = ELEM_W'($urandom_range(0, hi));
        rel_pairs.push_back(p);
      end
    end
    if (rel_pairs.size() == 0) begin
      p.x = ELEM_W'($urandom_range(0, hi));
      p.y = ELEM_W'($urandom_range(0, hi));
      rel_pairs.push_back(p);
    end
    // arrival order should not matter to the flags
    for (int i = rel_pairs.size() - 1; i > 0; i--) begin
      j            = $urandom_range(0, i);
      p            = rel_pairs[i];
      rel_pairs[i] = rel_pairs[j];
      rel_pairs[j] = p;
    end
  endtask

  initial begin : stimulus
    int n_sent;
    int pick;
    int dom;
    int n_eff;
    int n_rel;
    bit burst;
    bit big_done;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // ---- directed: reset domain (256) ----
    // top and bottom corners, single pair: a function, far from total
    send_pair(9'd256, 9'd1, 1'b1);
    // zero element
    send_pair(9'd0, 9'd5, 1'b1);
    // repeated identical pair is harmless, a second image is not
    send_pair(9'd1, 9'd256, 1'b0);
    send_pair(9'd1, 9'd256, 1'b0);
    send_pair(9'd1, 9'd255, 1'b1);

    // ---- directed: domain of four ----
    write_domain(9'd4);
    // cyclic permutation: every property flag high, no range error
    send_pair(9'd1, 9'd2, 1'b0);
    send_pair(9'd2, 9'd3, 1'b0);
    send_pair(9'd3, 9'd4, 1'b0);
    send_pair(9'd4, 9'd1, 1'b1);
    // constant map: total, neither injective nor surjective
    send_pair(9'd1, 9'd1, 1'b0);
    rest(3, 1'b0);
    send_pair(9'd2, 9'd1, 1'b0);
    send_pair(9'd3, 9'd1, 1'b0);
    send_pair(9'd4, 9'd1, 1'b1);
    // source just above n
    send_pair(9'd5, 9'd1, 1'b1);
    // target just above n after a good pair
    send_pair(9'd2, 9'd2, 1'b0);
    send_pair(9'd1, 9'd5, 1'b1);

    // ---- directed: smallest, zero and oversized domains ----
    write_domain(9'd1);
    send_pair(9'd1, 9'd1, 1'b1);
    send_pair(9'd1, 9'd256, 1'b1);
    // nothing is in range with an empty base set
    write_domain(9'd0);
    send_pair(9'd1, 9'd1, 1'b1);
    // above the table size acts as the full table
    write_domain(9'd511);
    send_pair(9'd256, 9'd256, 1'b1);

    // ---- random phases ----
    // Each phase picks a domain size, mostly small so that total and
    // surjective relations are cheap to build; the first wide phase sends
    // one full permutation of all 256 elements.
    n_sent   = 0;
    big_done = 1'b0;
    while (n_sent < 400) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        dom = 0;
      end else if (pick == 1) begin
        dom = $urandom_range(MAX_ELEMS + 1, 511);
      end else if (pick < 4) begin
        dom = big_done ? $urandom_range(200, MAX_ELEMS) : MAX_ELEMS;
      end else begin
        dom = $urandom_range(1, 8);
      end
      write_domain(ELEM_W'(dom));
      n_eff = (dom > MAX_ELEMS) ? MAX_ELEMS : dom;
      // some phases run flat out with no gaps at all
      burst = ($urandom_range(0, 3) == 0);
      n_rel = $urandom_range(1, 6);
      repeat (n_rel) begin
        build_relation(n_eff, !big_done && n_eff == MAX_ELEMS);
        if (n_eff == MAX_ELEMS) big_done = 1'b1;
        for (int i = 0; i < rel_pairs.size(); i++) begin
          send_pair(rel_pairs[i].x, rel_pairs[i].y, i == rel_pairs.size() - 1);
          n_sent++;
          rest(burst ? 0 : gap_len(), 1'b0);
        end
        // now and then hold off until the result is out
        if ($urandom_range(0, 4) == 0) rest(gap_len(), 1'b1);
      end
    end

    // let the last results through, then a few quiet cycles
    rest(0, 1'b1);
    repeat (10) @(posedge clk);
    if (fails == 0 && flags_pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, clearing passes included.
  initial begin : watchdog
    #2_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
